// File: hdl/hex_frame_checksum_check_defines.svh
// ----------------------------------------------------------------------------
// hex frame checksum check: assertion macros
// shared macros for the concurrent checks on the block ports
// ----------------------------------------------------------------------------
`ifndef HEX_FRAME_CHECKSUM_CHECK_DEFINES_SVH
`define HEX_FRAME_CHECKSUM_CHECK_DEFINES_SVH

// checked only outside reset
`define HFCC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("hfcc check failed");

// checked at every edge, reset included
`define HFCC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("hfcc check failed");

`endif

// File: hdl/hfcc_pkg.sv
// ----------------------------------------------------------------------------
// hfcc_pkg
// types, constants and the nibble decoder of the hex frame checksum check
// ----------------------------------------------------------------------------
package hfcc_pkg;

  localparam int unsigned ChW     = 8;
  localparam int unsigned NibW    = 4;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned IdxW    = 9;
  localparam int unsigned SkipW   = 2;
  localparam int unsigned OutDataW = 8;

  localparam logic [SkipW-1:0] SkipChars = 2'd2;

  typedef struct packed {
    logic [ChW-1:0] ch;
    logic           last;
  } item_t;

  typedef struct packed {
    logic adv;
    logic fin;
  } ctl_t;

  function automatic logic [NibW-1:0] decode_nibble(input logic [ChW-1:0] c);
    logic [NibW-1:0] n;
    n = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      n = NibW'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      n = NibW'(c - 8'h37);
    end
    return n;
  endfunction

endpackage

// File: hdl/hex_frame_checksum_check.sv
// ----------------------------------------------------------------------------
// hex_frame_checksum_check
// checks the 8-bit additive checksum of a frame sent as ascii hex text
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one ascii character per item in tdata, tlast ends a frame
//   m_axis carries one item per frame, pass or fail in tdata bit 0
//   the first two characters are skipped, then digit pairs form bytes:
//   byte 0 is the length, bytes 1 to length-1 are summed, byte length is
//   the check byte
//   one item per cycle is accepted unless a last item waits; each item is held
//   in the input register and folded into the frame state, summed bytes by an 8-bit add
//   the last item passes the input register, then its result is held in the
//   result register
//   reset clears the frame state and empties both registers
//   while the receiver stalls, non-last items keep flowing; a last item
//   waits in the input register until the result register is free
// ----------------------------------------------------------------------------
module hex_frame_checksum_check (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] ch
  input  logic       s_axis_tlast_i,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o    // [0] pack_ok, [7:1] zero
);

  hfcc_pkg::item_t in_item;
  hfcc_pkg::item_t reg_item;
  hfcc_pkg::ctl_t  ctl;
  logic            out_free;
  logic            ok_comb;
  logic            ok_reg;

  assign in_item.ch   = s_axis_tdata_i;
  assign in_item.last = s_axis_tlast_i;

  hfcc_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s_axis_tvalid_i),
    .ready_o    (s_axis_tready_o),
    .item_i     (in_item),
    .out_free_i (out_free),
    .item_o     (reg_item),
    .ctl_o      (ctl)
  );

  hfcc_frame_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (reg_item),
    .ctl_i     (ctl),
    .pack_ok_o (ok_comb)
  );

  hfcc_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .pack_ok_i  (ok_comb),
    .out_free_o (out_free),
    .valid_o    (m_axis_tvalid_o),
    .ready_i    (m_axis_tready_i),
    .pack_ok_o  (ok_reg)
  );

  assign m_axis_tdata_o = {{(hfcc_pkg::OutDataW-1){1'b0}}, ok_reg};

endmodule

// File: hdl/hfcc_in_stage.sv
// ----------------------------------------------------------------------------
// hfcc_in_stage
// input register; frees itself when the held item moves on
// ----------------------------------------------------------------------------
module hfcc_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  hfcc_pkg::item_t     item_i,
  input  logic                out_free_i,
  output hfcc_pkg::item_t     item_o,
  output hfcc_pkg::ctl_t      ctl_o
);

  logic            vld_q, vld_d;
  hfcc_pkg::item_t item_q;
  logic            adv;
  logic            take;

  // a non-last item never waits on the output side
  assign adv     = vld_q && (!item_q.last || out_free_i);
  assign ready_o = !vld_q || adv;
  assign take    = valid_i && ready_o;
  assign vld_d   = take ? 1'b1 : (adv ? 1'b0 : vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_i;
    end
  end

  assign item_o     = item_q;
  assign ctl_o.adv  = adv;
  assign ctl_o.fin  = adv && item_q.last;

endmodule

// File: hdl/hfcc_frame_core.sv
// ----------------------------------------------------------------------------
// hfcc_frame_core
// frame state: skip, nibble pairing, length, running sum and check byte
// ----------------------------------------------------------------------------
module hfcc_frame_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hfcc_pkg::item_t  item_i,
  input  hfcc_pkg::ctl_t   ctl_i,
  output logic             pack_ok_o
);

  logic [hfcc_pkg::SkipW-1:0] skip_q, skip_d;
  logic                       phase_q, phase_d;
  logic [hfcc_pkg::NibW-1:0]  hi_q, hi_d;
  logic [hfcc_pkg::IdxW-1:0]  idx_q, idx_d;
  logic [hfcc_pkg::ByteW-1:0] len_q, len_d;
  logic [hfcc_pkg::ByteW-1:0] sum_q, sum_d;
  logic [hfcc_pkg::ByteW-1:0] chk_q, chk_d;
  logic [hfcc_pkg::NibW-1:0]  nib;
  logic [hfcc_pkg::ByteW-1:0] byte_v;
  logic [hfcc_pkg::ByteW-1:0] len_eff;

  always_comb begin
    nib     = hfcc_pkg::decode_nibble(item_i.ch);
    byte_v  = {hi_q, nib};
    skip_d  = skip_q;
    phase_d = phase_q;
    hi_d    = hi_q;
    idx_d   = idx_q;
    len_d   = len_q;
    sum_d   = sum_q;
    chk_d   = chk_q;
    len_eff = (idx_q == '0) ? byte_v : len_q;
    if (skip_q < hfcc_pkg::SkipChars) begin
      skip_d = skip_q + 1'b1;
    end else if (!phase_q) begin
      hi_d    = nib;
      phase_d = 1'b1;
    end else begin
      phase_d = 1'b0;
      // index 256 and above is dropped
      if (!idx_q[hfcc_pkg::IdxW-1]) begin
        if (idx_q == '0) begin
          len_d = byte_v;
        end else if (idx_q < {1'b0, len_q}) begin
          sum_d = sum_q + byte_v;
        end
        if (idx_q == {1'b0, len_eff}) begin
          chk_d = byte_v;
        end
        idx_d = idx_q + 1'b1;
      end
    end
    pack_ok_o = (sum_d == chk_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q  <= '0;
      phase_q <= 1'b0;
      hi_q    <= '0;
      idx_q   <= '0;
      len_q   <= '0;
      sum_q   <= '0;
      chk_q   <= '0;
    end else if (ctl_i.fin) begin
      skip_q  <= '0;
      phase_q <= 1'b0;
      hi_q    <= '0;
      idx_q   <= '0;
      len_q   <= '0;
      sum_q   <= '0;
      chk_q   <= '0;
    end else if (ctl_i.adv) begin
      skip_q  <= skip_d;
      phase_q <= phase_d;
      hi_q    <= hi_d;
      idx_q   <= idx_d;
      len_q   <= len_d;
      sum_q   <= sum_d;
      chk_q   <= chk_d;
    end
  end

endmodule

// File: hdl/hfcc_out_stage.sv
// ----------------------------------------------------------------------------
// hfcc_out_stage
// result register holding the pass or fail item until taken
// ----------------------------------------------------------------------------
module hfcc_out_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  hfcc_pkg::ctl_t  ctl_i,
  input  logic            pack_ok_i,
  output logic            out_free_o,
  output logic            valid_o,
  input  logic            ready_i,
  output logic            pack_ok_o
);

  logic vld_q, vld_d;
  logic ok_q;

  assign out_free_o = !vld_q || ready_i;
  assign vld_d      = ctl_i.fin ? 1'b1 : (ready_i ? 1'b0 : vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.fin) begin
      ok_q <= pack_ok_i;
    end
  end

  assign valid_o   = vld_q;
  assign pack_ok_o = ok_q;

endmodule

// File: hdl/hfcc_checker.sv
// ----------------------------------------------------------------------------
// hfcc_checker
// port-level checks of the hex frame checksum check, bound to the top level
// ----------------------------------------------------------------------------
`include "hex_frame_checksum_check_defines.svh"

module hfcc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o
);

  `HFCC_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |-> !m_axis_tvalid_o)

  `HFCC_ASSERT(a_stall_holds,
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))

  `HFCC_ASSERT(a_backpressure_cause, !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)

  `HFCC_ASSERT(a_pad_zero, m_axis_tvalid_o |-> m_axis_tdata_o[7:1] == 7'd0)

endmodule

bind hex_frame_checksum_check hfcc_checker u_hfcc_checker (.*);
